// ----- src/atrd_pkg.sv -----
// shared types and constants for the at response deframer
package atrd_pkg;
  localparam logic [1:0] ACT_BYTE  = 2'd0;
  localparam logic [1:0] ACT_CMD   = 2'd1;
  localparam logic [1:0] ACT_ABORT = 2'd2;
  localparam logic [1:0] ACT_DRAIN = 2'd3;

  localparam logic [4:0] EV_PAYLOAD  = 5'd0;
  localparam logic [4:0] EV_READY    = 5'd1;
  localparam logic [4:0] EV_WCONN    = 5'd2;
  localparam logic [4:0] EV_WGOT     = 5'd3;
  localparam logic [4:0] EV_WLOST    = 5'd4;
  localparam logic [4:0] EV_MCONN    = 5'd5;
  localparam logic [4:0] EV_MDISC    = 5'd6;
  localparam logic [4:0] EV_PUBOK    = 5'd7;
  localparam logic [4:0] EV_PUBFAIL  = 5'd8;
  localparam logic [4:0] EV_MSG      = 5'd9;
  localparam logic [4:0] EV_HTTP     = 5'd10;
  localparam logic [4:0] EV_JOINERR  = 5'd11;
  localparam logic [4:0] EV_DEVERR   = 5'd12;
  localparam logic [4:0] EV_BUSY     = 5'd13;
  localparam logic [4:0] EV_PROMPT   = 5'd14;
  localparam logic [4:0] EV_OK       = 5'd15;
  localparam logic [4:0] EV_ERROR    = 5'd16;
  localparam logic [4:0] EV_LINE     = 5'd17;

  localparam int NPAT = 20;
  localparam int P_READY = 0, P_WIFI = 1, P_WCONN = 2, P_WGOT = 3, P_WDISC = 4;
  localparam int P_MQTT = 5, P_MCONN = 6, P_MDISC = 7, P_PUBOK = 8, P_PUBFAIL = 9;
  localparam int P_SUBRECV = 10, P_HTTP = 11, P_CWJAP = 12, P_ERRC = 13, P_BUSY = 14;
  localparam int P_PROMPT = 15, P_OK = 16, P_ERROR = 17, P_FAIL = 18, P_IPD = 19;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] rx_byte;
  } req_t;

  typedef struct packed {
    logic [4:0]  event_res;
    logic [31:0] value;
    logic [15:0] message_length;
    logic [7:0]  payload_byte;
    logic        last_of_frame;
    logic        frame_dropped;
    logic [2:0]  wifi_status;
    logic        mqtt_up;
    logic        command_busy;
  } res_t;

  typedef struct packed {
    logic [31:0] mag;
    logic [2:0]  phase;
    logic        neg;
    logic        over;
  } num_t;

  localparam logic [2:0] PH_LEAD = 3'd0, PH_SIGN = 3'd1, PH_DIG = 3'd2, PH_DONE = 3'd3,
                         PH_ZERO = 3'd4, PH_HEX = 3'd5;

  function automatic logic [4:0] pat_len(input int i);
    logic [4:0] l;
    unique case (i)
      0: l = 5; 1: l = 5; 2: l = 14; 3: l = 11; 4: l = 15; 5: l = 5; 6: l = 14;
      7: l = 17; 8: l = 11; 9: l = 13; 10: l = 12; 11: l = 11; 12: l = 7; 13: l = 9;
      14: l = 6; 15: l = 1; 16: l = 2; 17: l = 5; 18: l = 4; default: l = 4;
    endcase
    return l;
  endfunction

  function automatic logic [7:0] pat_chr(input int i, input logic [4:0] p);
    logic [8*17-1:0] s;
    logic [4:0] l;
    unique case (i)
      0: s = {"ready", 96'd0};
      1: s = {"WIFI ", 96'd0};
      2: s = {"WIFI CONNECTED", 24'd0};
      3: s = {"WIFI GOT IP", 48'd0};
      4: s = {"WIFI DISCONNECT", 16'd0};
      5: s = {"+MQTT", 96'd0};
      6: s = {"+MQTTCONNECTED", 24'd0};
      7: s = "+MQTTDISCONNECTED";
      8: s = {"+MQTTPUB:OK", 48'd0};
      9: s = {"+MQTTPUB:FAIL", 32'd0};
      10: s = {"+MQTTSUBRECV", 40'd0};
      11: s = {"+HTTPCLIENT", 48'd0};
      12: s = {"+CWJAP:", 80'd0};
      13: s = {"ERR CODE:", 64'd0};
      14: s = {"busy p", 88'd0};
      15: s = {">", 128'd0};
      16: s = {"OK", 120'd0};
      17: s = {"ERROR", 96'd0};
      18: s = {"FAIL", 104'd0};
      default: s = {"+IPD", 104'd0};
    endcase
    l = pat_len(i);
    if (p >= l) return 8'd0;
    return s[8*(16 - 32'(p)) +: 8];
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
  endfunction

  function automatic num_t num_acc(input num_t n, input logic [3:0] d, input logic hex);
    num_t r;
    logic [35:0] prod;
    r = n;
    if (!n.over) begin
      prod = hex ? ({4'd0, n.mag} << 4) : ({4'd0, n.mag} * 36'd10);
      prod = prod + 36'(d);
      if (prod[35:32] != 4'd0) r.over = 1'b1;
      else r.mag = prod[31:0];
    end
    return r;
  endfunction

  function automatic num_t num_feed(input num_t n, input logic [7:0] c, input logic hex);
    num_t r;
    logic dv;
    logic [3:0] d;
    logic [2:0] ph;
    r = n;
    dv = 1'b0;
    d = 4'd0;
    if (c >= "0" && c <= "9") begin
      dv = 1'b1; d = 4'(c - "0");
    end else if (hex && c >= "a" && c <= "f") begin
      dv = 1'b1; d = 4'(c - "a" + 8'd10);
    end else if (hex && c >= "A" && c <= "F") begin
      dv = 1'b1; d = 4'(c - "A" + 8'd10);
    end
    ph = n.phase;
    if (ph == PH_LEAD) begin
      if (is_space(c)) return r;
      if (c == "+" || c == "-") begin
        r.neg = (c == "-");
        r.phase = PH_SIGN;
        return r;
      end
      ph = PH_SIGN;
    end
    r.phase = ph;
    priority case (ph)
      PH_SIGN: begin
        if (hex && c == "0") r.phase = PH_ZERO;
        else if (dv) begin r = num_acc(r, d, hex); r.phase = PH_DIG; end
        else r.phase = PH_DONE;
      end
      PH_DIG, PH_HEX: begin
        if (dv) begin r = num_acc(r, d, hex); r.phase = PH_DIG; end
        else r.phase = PH_DONE;
      end
      PH_ZERO: begin
        if (c == "x" || c == "X") r.phase = PH_HEX;
        else if (dv) begin r = num_acc(r, d, hex); r.phase = PH_DIG; end
        else r.phase = PH_DONE;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] num_dec(input num_t n);
    logic [31:0] lim;
    lim = n.neg ? 32'h8000_0000 : 32'h7fff_ffff;
    if (n.over || n.mag > lim) return lim;
    return n.neg ? (32'd0 - n.mag) : n.mag;
  endfunction

  function automatic logic [31:0] num_hex(input num_t n);
    if (n.over) return 32'hffff_ffff;
    return n.neg ? (32'd0 - n.mag) : n.mag;
  endfunction
endpackage

// ----- src/atrd_front.sv -----
// front end: accepts requests and registers them into the queue
`default_nettype none
module atrd_front import atrd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] action,
  input  wire logic [7:0] rx_byte,
  output logic            q_valid,
  output req_t            q_data,
  input  wire logic       q_ready
);
  req_t mem [2];
  logic wp, rp;
  logic [1:0] cnt;

  assign in_ready = cnt != 2'd2;
  assign q_valid  = cnt != 2'd0;
  assign q_data   = mem[rp];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) mem[wp] <= '{action: action, rx_byte: rx_byte};
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; cnt <= 2'd0;
    end else begin
      if (in_valid && in_ready) wp <= ~wp;
      if (q_valid && q_ready) rp <= ~rp;
      cnt <= cnt + 2'(in_valid && in_ready) - 2'(q_valid && q_ready);
    end
  end
endmodule
`default_nettype wire

// ----- src/atrd_back.sv -----
// back end: line parser, frame deframer and result register
`default_nettype none
module atrd_back import atrd_pkg::*; #(
  parameter int LINE_BYTES = 128,
  parameter int FRAME_BUFFER_BYTES = 2048,
  parameter int HEADER_BYTES = 24
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic q_valid,
  input  wire req_t q_data,
  output logic      q_ready,
  output logic      out_valid,
  output res_t      out_data,
  input  wire logic out_ready
);
  localparam int LW = $clog2(LINE_BYTES + 1);
  localparam int FW = $clog2(FRAME_BUFFER_BYTES + 1);
  localparam int HW = $clog2(HEADER_BYTES + 1);
  localparam int HL = (HEADER_BYTES - 1 < LINE_BYTES - 1) ? HEADER_BYTES - 1 : LINE_BYTES - 1;
  localparam logic [1:0] MODE_LINE = 2'd0, MODE_HEADER = 2'd1, MODE_BODY = 2'd2;

  logic [1:0] parse_mode, parse_mode_next;
  logic [LW-1:0] line_count, line_count_next, trim_len, trim_len_next;
  logic [NPAT-1:0] prefix_alive, prefix_alive_next;
  num_t number_accum, number_accum_next, comma_num, comma_num_next;
  logic [15:0] cv0, cv0_next, body_remaining, body_remaining_next;
  logic [1:0] comma_count, comma_count_next;
  logic [FW-1:0] buffer_fill, buffer_fill_next;
  logic discard_body, discard_body_next, key_on, key_on_next, key_hex, key_hex_next;
  logic hdr_comma, hdr_comma_next;
  logic [HW-1:0] hdr_count, hdr_count_next;
  logic [2:0] link_state, link_state_next;
  logic broker_up, broker_up_next, awaiting, awaiting_next;

  logic fire, emit;
  res_t res;
  logic [4:0] ev;
  logic [31:0] val;
  logic [15:0] msg;
  logic [7:0] pb;
  logic last, drop;

  assign q_ready = !out_valid || out_ready;
  assign fire = q_valid && q_ready;

  function automatic logic hasp(input logic [NPAT-1:0] a, input logic [LW-1:0] t,
                                input int i);
    return a[i] && (32'(t) >= 32'(pat_len(i)));
  endfunction
  function automatic logic samep(input logic [NPAT-1:0] a, input logic [LW-1:0] t,
                                 input int i);
    return a[i] && (32'(t) == 32'(pat_len(i)));
  endfunction

  always_comb begin
    logic [7:0] c;
    logic [31:0] kv, len, cdec;
    logic [15:0] ml;
    logic [LW-1:0] pos;
    logic [NPAT-1:0] a;
    logic [LW-1:0] t;
    logic finish, bodyline;
    logic [16:0] fsum;
    c = q_data.rx_byte;
    parse_mode_next = parse_mode; line_count_next = line_count; trim_len_next = trim_len;
    prefix_alive_next = prefix_alive; number_accum_next = number_accum;
    comma_num_next = comma_num; cv0_next = cv0; comma_count_next = comma_count;
    body_remaining_next = body_remaining; buffer_fill_next = buffer_fill;
    discard_body_next = discard_body; key_on_next = key_on; key_hex_next = key_hex;
    hdr_comma_next = hdr_comma; hdr_count_next = hdr_count;
    link_state_next = link_state; broker_up_next = broker_up; awaiting_next = awaiting;
    emit = 1'b0; ev = EV_PAYLOAD; val = '0; msg = '0; pb = '0; last = 1'b0; drop = 1'b0;
    finish = 1'b0; bodyline = 1'b0;
    pos = line_count; a = prefix_alive; t = trim_len;
    kv = key_on ? (key_hex ? num_hex(number_accum) : num_dec(number_accum)) : 32'd0;
    ml = (comma_count >= 2'd2) ? cv0 : 16'd0;
    len = num_dec(number_accum);
    cdec = num_dec(comma_num);
    fsum = 17'(buffer_fill) + 17'(len[15:0]);
    unique case (q_data.action)
      ACT_CMD: awaiting_next = 1'b1;
      ACT_ABORT: awaiting_next = 1'b0;
      ACT_DRAIN: buffer_fill_next = '0;
      default: begin
        if (parse_mode == MODE_HEADER) begin
          hdr_count_next = hdr_count + 1'b1;
          if (c == ":") begin
            parse_mode_next = MODE_LINE;
            line_count_next = '0; trim_len_next = '0; prefix_alive_next = '1;
            number_accum_next = '0; key_on_next = 1'b0; key_hex_next = 1'b0;
            comma_num_next = '0; cv0_next = '0; comma_count_next = '0;
            if (!hdr_comma || len < 32'd1 || len > 32'd65535) begin
              emit = 1'b1; drop = 1'b1;
            end else begin
              body_remaining_next = len[15:0];
              discard_body_next = fsum > 17'(FRAME_BUFFER_BYTES);
              parse_mode_next = MODE_BODY;
              if (fsum > 17'(FRAME_BUFFER_BYTES)) begin emit = 1'b1; drop = 1'b1; end
            end
          end else if (32'(hdr_count_next) >= 32'(HEADER_BYTES)) begin
            parse_mode_next = MODE_LINE;
            line_count_next = LW'(HL); trim_len_next = LW'(HL); prefix_alive_next = '0;
            number_accum_next = '0; key_on_next = 1'b0; key_hex_next = 1'b0;
            comma_num_next = '0; cv0_next = '0; comma_count_next = '0;
            emit = 1'b1; drop = 1'b1;
          end else if (c == ",") begin
            hdr_comma_next = 1'b1; number_accum_next = '0;
          end else number_accum_next = num_feed(number_accum, c, 1'b0);
        end else if (parse_mode == MODE_BODY && body_remaining != 16'd0) begin
          body_remaining_next = body_remaining - 16'd1;
          last = body_remaining == 16'd1;
          if (last) parse_mode_next = MODE_LINE;
          if (discard_body) begin
            if (last) discard_body_next = 1'b0;
            last = 1'b0;
          end else begin
            if (32'(buffer_fill) < 32'(FRAME_BUFFER_BYTES)) buffer_fill_next = buffer_fill + 1'b1;
            emit = 1'b1; pb = c;
          end
        end else begin
          bodyline = 1'b1;
        end
      end
    endcase
    if (bodyline) begin
      parse_mode_next = MODE_LINE;
      if (c == 8'h0a || 32'(pos) >= 32'(LINE_BYTES - 1)) finish = 1'b1;
      else begin
        for (int i = 0; i < NPAT; i++)
          if (32'(pos) < 32'(pat_len(i)) && pat_chr(i, pos[4:0]) != c)
            prefix_alive_next[i] = 1'b0;
        if (pos == LW'(3) && prefix_alive_next[P_IPD]) begin
          parse_mode_next = MODE_HEADER;
          hdr_count_next = HW'(4); hdr_comma_next = 1'b0; number_accum_next = '0;
        end else begin
          if (key_on) number_accum_next = num_feed(number_accum, c, key_hex);
          else begin
            priority if (pos == LW'(14) && prefix_alive_next[P_MCONN]) begin
              key_on_next = 1'b1;
              if (c != "=" && c != ":") number_accum_next = num_feed(number_accum, c, 1'b0);
            end else if (pos == LW'(17) && prefix_alive_next[P_MDISC]) begin
              key_on_next = 1'b1;
              if (c != "=" && c != ":") number_accum_next = num_feed(number_accum, c, 1'b0);
            end else if (pos == LW'(12) && prefix_alive_next[P_SUBRECV]) begin
              key_on_next = 1'b1;
              if (c != "=" && c != ":") number_accum_next = num_feed(number_accum, c, 1'b0);
            end else if (pos == LW'(11) && prefix_alive_next[P_HTTP]) begin
              key_on_next = 1'b1;
              if (c != "=" && c != ":") number_accum_next = num_feed(number_accum, c, 1'b0);
            end else if (pos == LW'(6) && prefix_alive_next[P_CWJAP]) begin
              key_on_next = 1'b1;
              if (c != "=" && c != ":") number_accum_next = num_feed(number_accum, c, 1'b0);
            end else if (pos == LW'(8) && prefix_alive_next[P_ERRC]) begin
              key_on_next = 1'b1; key_hex_next = 1'b1;
              if (c != "=" && c != ":") number_accum_next = num_feed(number_accum, c, 1'b1);
            end else begin
            end
          end
          if (c == ",") begin
            cv0_next = cdec[15:0];
            if (comma_count < 2'd2) comma_count_next = comma_count + 2'd1;
            comma_num_next = '0;
          end else comma_num_next = num_feed(comma_num, c, 1'b0);
          if (c != 8'h0d && c != 8'h20) trim_len_next = pos + 1'b1;
          line_count_next = pos + 1'b1;
        end
      end
    end
    if (finish) begin
      line_count_next = '0; trim_len_next = '0; prefix_alive_next = '1;
      number_accum_next = '0; key_on_next = 1'b0; key_hex_next = 1'b0;
      comma_num_next = '0; cv0_next = '0; comma_count_next = '0;
      if (t != '0) begin
        emit = 1'b1;
        priority if (samep(a, t, P_READY)) begin link_state_next = 3'd1; ev = EV_READY; end
        else if (hasp(a, t, P_WIFI)) begin
          priority if (hasp(a, t, P_WCONN)) begin link_state_next = 3'd2; ev = EV_WCONN; end
          else if (hasp(a, t, P_WGOT)) begin link_state_next = 3'd3; ev = EV_WGOT; end
          else if (hasp(a, t, P_WDISC)) begin link_state_next = 3'd4; ev = EV_WLOST; end
          else emit = 1'b0;
        end else if (hasp(a, t, P_MQTT)) begin
          priority if (hasp(a, t, P_MCONN)) begin broker_up_next = 1'b1; ev = EV_MCONN; val = kv; end
          else if (hasp(a, t, P_MDISC)) begin broker_up_next = 1'b0; ev = EV_MDISC; val = kv; end
          else if (hasp(a, t, P_PUBOK)) ev = EV_PUBOK;
          else if (hasp(a, t, P_PUBFAIL)) ev = EV_PUBFAIL;
          else if (hasp(a, t, P_SUBRECV)) begin ev = EV_MSG; val = kv; msg = ml; end
          else emit = 1'b0;
        end else if (hasp(a, t, P_HTTP)) begin ev = EV_HTTP; val = {16'd0, kv[15:0]}; end
        else if (hasp(a, t, P_CWJAP)) begin link_state_next = 3'd4; ev = EV_JOINERR; val = kv; end
        else if (hasp(a, t, P_ERRC)) begin ev = EV_DEVERR; val = kv; end
        else if (hasp(a, t, P_BUSY)) begin
          if (awaiting) begin awaiting_next = 1'b0; ev = EV_BUSY; end
          else emit = 1'b0;
        end else if (hasp(a, t, P_PROMPT)) ev = EV_PROMPT;
        else if (awaiting) begin
          priority if (samep(a, t, P_OK)) begin awaiting_next = 1'b0; ev = EV_OK; end
          else if (samep(a, t, P_ERROR) || samep(a, t, P_FAIL)) begin
            awaiting_next = 1'b0; ev = EV_ERROR;
          end else ev = EV_LINE;
        end else emit = 1'b0;
      end
    end
    res = '{event_res: ev, value: val, message_length: msg, payload_byte: pb,
            last_of_frame: last, frame_dropped: drop, wifi_status: link_state_next,
            mqtt_up: broker_up_next, command_busy: awaiting_next};
  end

  always_ff @(posedge clk) begin
    if (fire && emit) out_data <= res;
    if (rst) begin
      out_valid <= 1'b0;
      parse_mode <= MODE_LINE; line_count <= '0; trim_len <= '0; prefix_alive <= '1;
      number_accum <= '0; comma_num <= '0; cv0 <= '0; comma_count <= '0;
      body_remaining <= '0; buffer_fill <= '0; discard_body <= 1'b0;
      key_on <= 1'b0; key_hex <= 1'b0; hdr_comma <= 1'b0; hdr_count <= '0;
      link_state <= '0; broker_up <= 1'b0; awaiting <= 1'b0;
    end else begin
      if (fire) out_valid <= emit;
      else if (out_ready) out_valid <= 1'b0;
      if (fire) begin
        parse_mode <= parse_mode_next; line_count <= line_count_next;
        trim_len <= trim_len_next; prefix_alive <= prefix_alive_next;
        number_accum <= number_accum_next; comma_num <= comma_num_next;
        cv0 <= cv0_next; comma_count <= comma_count_next;
        body_remaining <= body_remaining_next; buffer_fill <= buffer_fill_next;
        discard_body <= discard_body_next; key_on <= key_on_next; key_hex <= key_hex_next;
        hdr_comma <= hdr_comma_next; hdr_count <= hdr_count_next;
        link_state <= link_state_next; broker_up <= broker_up_next;
        awaiting <= awaiting_next;
      end
    end
  end
endmodule
`default_nettype wire

// ----- src/at_response_line_and_ipd_deframer_unit.sv -----
// top level of the at response line parser and frame deframer
//  channel | direction | handshake             | payload
//  in      | input     | in_valid / in_ready   | action, rx_byte
//  out     | output    | out_valid / out_ready | event_res .. command_busy
// one request per cycle sustained while the output is not stalled; the parser step sets the rate
// a two-entry queue in the front feeds the parser back end
// each result is registered and appears in the cycle after the parser takes its request
// synchronous reset returns to line mode with all flags cleared
// a stalled output holds the parser while the queue keeps filling
`default_nettype none
module at_response_line_and_ipd_deframer_unit import atrd_pkg::*; #(
  parameter int LINE_BYTES = 128,
  parameter int FRAME_BUFFER_BYTES = 2048,
  parameter int HEADER_BYTES = 24
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  action,
  input  wire logic [7:0]  rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [4:0]       event_res,
  output logic [31:0]      value,
  output logic [15:0]      message_length,
  output logic [7:0]       payload_byte,
  output logic             last_of_frame,
  output logic             frame_dropped,
  output logic [2:0]       wifi_status,
  output logic             mqtt_up,
  output logic             command_busy
);
  logic q_valid, q_ready;
  req_t q_data;
  res_t r;

  atrd_front u_front (
    .clk, .rst, .in_valid, .in_ready, .action, .rx_byte,
    .q_valid, .q_data, .q_ready
  );

  atrd_back #(
    .LINE_BYTES(LINE_BYTES), .FRAME_BUFFER_BYTES(FRAME_BUFFER_BYTES),
    .HEADER_BYTES(HEADER_BYTES)
  ) u_back (
    .clk, .rst, .q_valid, .q_data, .q_ready, .out_valid, .out_data(r), .out_ready
  );

  assign event_res = r.event_res;
  assign value = r.value;
  assign message_length = r.message_length;
  assign payload_byte = r.payload_byte;
  assign last_of_frame = r.last_of_frame;
  assign frame_dropped = r.frame_dropped;
  assign wifi_status = r.wifi_status;
  assign mqtt_up = r.mqtt_up;
  assign command_busy = r.command_busy;
endmodule
`default_nettype wire

// ----- bench/tb_top.sv -----
// testbench for the at response line parser and ipd frame deframer
`timescale 1ns / 1ps
module tb_top;
  import atrd_pkg::*;

  localparam int LINE_MAX = 128;
  localparam int FBUF_MAX = 2048;
  localparam int HDR_MAX = 24;
  localparam int LIMIT = 2000000;
  localparam logic [1:0] MODE_LINE = 2'd0, MODE_HDR = 2'd1, MODE_BODY = 2'd2;

  typedef struct packed {
    logic [31:0] mag;
    logic [2:0]  ph;
    logic        neg;
    logic        ovf;
  } digits_t;

  typedef struct {
    logic [1:0] act;
    logic [7:0] chr;
    bit         fixed;
    logic [4:0] ev;
  } request_t;

  typedef struct {
    logic [1:0] act;
    string      txt;
    bit         fixed;
    logic [4:0] ev;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] action = ACT_BYTE;
  logic [7:0] rx_byte = 8'd0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [4:0] event_res;
  logic [31:0] value;
  logic [15:0] message_length;
  logic [7:0] payload_byte;
  logic last_of_frame, frame_dropped, mqtt_up, command_busy;
  logic [2:0] wifi_status;

  bit cur_fixed = 1'b0;
  logic [4:0] cur_ev = 5'd0;
  request_t stim_q[$];
  res_t events_due[$];
  int errors = 0;
  int cyc = 0;
  bit stall_req = 0;

  always #5 clk = ~clk;

  at_response_line_and_ipd_deframer_unit i_dut (
    .clk, .rst, .in_valid, .in_ready, .action, .rx_byte, .out_valid, .out_ready,
    .event_res, .value, .message_length, .payload_byte, .last_of_frame,
    .frame_dropped, .wifi_status, .mqtt_up, .command_busy
  );

  // parser state mirror
  string words[NPAT] = '{"ready", "WIFI ", "WIFI CONNECTED", "WIFI GOT IP",
    "WIFI DISCONNECT", "+MQTT", "+MQTTCONNECTED", "+MQTTDISCONNECTED", "+MQTTPUB:OK",
    "+MQTTPUB:FAIL", "+MQTTSUBRECV", "+HTTPCLIENT", "+CWJAP:", "ERR CODE:", "busy p",
    ">", "OK", "ERROR", "FAIL", "+IPD"};
  int key_word[6] = '{P_MCONN, P_MDISC, P_SUBRECV, P_HTTP, P_CWJAP, P_ERRC};
  int key_at[6] = '{14, 17, 12, 11, 6, 8};

  logic [1:0] mode;
  int unsigned held, trimmed, hdr_seen, body_left, fill;
  logic [NPAT-1:0] alive;
  digits_t keynum, commanum;
  logic [15:0] comma0, comma1;
  int comma_n;
  bit hdr_comma, key_on, key_hex, discard, broker, waiting;
  logic [2:0] link;

  function automatic int digit_val(logic [7:0] c, bit hex);
    if (c >= "0" && c <= "9") return c - "0";
    if (hex && c >= "a" && c <= "f") return c - "a" + 10;
    if (hex && c >= "A" && c <= "F") return c - "A" + 10;
    return -1;
  endfunction

  function automatic digits_t digits_add(digits_t n, int d, bit hex);
    logic [35:0] p;
    if (n.ovf) return n;
    p = (hex ? 36'(n.mag) * 36'd16 : 36'(n.mag) * 36'd10) + 36'(d);
    if (p[35:32] != 0) n.ovf = 1'b1;
    else n.mag = p[31:0];
    return n;
  endfunction

  function automatic digits_t digits_take(digits_t n, logic [7:0] c, bit hex);
    int d;
    d = digit_val(c, hex);
    if (n.ph == PH_LEAD) begin
      if (c == " " || (c >= 8'h09 && c <= 8'h0d)) return n;
      if (c == "+" || c == "-") begin
        n.neg = (c == "-");
        n.ph = PH_SIGN;
        return n;
      end
      n.ph = PH_SIGN;
    end
    case (n.ph)
      PH_SIGN: begin
        if (hex && c == "0") n.ph = PH_ZERO;
        else if (d >= 0) begin n = digits_add(n, d, hex); n.ph = PH_DIG; end
        else n.ph = PH_DONE;
      end
      PH_DIG, PH_HEX: begin
        if (d >= 0) begin n = digits_add(n, d, hex); n.ph = PH_DIG; end
        else n.ph = PH_DONE;
      end
      PH_ZERO: begin
        if (c == "x" || c == "X") n.ph = PH_HEX;
        else if (d >= 0) begin n = digits_add(n, d, hex); n.ph = PH_DIG; end
        else n.ph = PH_DONE;
      end
      default: ;
    endcase
    return n;
  endfunction

  function automatic logic [31:0] as_decimal(digits_t n);
    logic [31:0] lim;
    lim = n.neg ? 32'h8000_0000 : 32'h7fff_ffff;
    if (n.ovf || n.mag > lim) return lim;
    return n.neg ? -n.mag : n.mag;
  endfunction

  function automatic logic [31:0] as_hexcode(digits_t n);
    if (n.ovf) return 32'hffff_ffff;
    return n.neg ? -n.mag : n.mag;
  endfunction

  function automatic void line_clear();
    held = 0;
    trimmed = 0;
    alive = '1;
    keynum = '0;
    commanum = '0;
    key_on = 0;
    key_hex = 0;
    comma0 = 0;
    comma1 = 0;
    comma_n = 0;
  endfunction

  function automatic res_t make_event(logic [4:0] ev, logic [31:0] v, logic [15:0] ml,
                                      logic [7:0] pb, bit last, bit drop);
    res_t r;
    r.event_res = ev;
    r.value = v;
    r.message_length = ml;
    r.payload_byte = pb;
    r.last_of_frame = last;
    r.frame_dropped = drop;
    r.wifi_status = link;
    r.mqtt_up = broker;
    r.command_busy = waiting;
    return r;
  endfunction

  function automatic bit starts(logic [NPAT-1:0] a, int unsigned t, int i);
    return a[i] && t >= words[i].len();
  endfunction

  function automatic bit exact(logic [NPAT-1:0] a, int unsigned t, int i);
    return a[i] && t == words[i].len();
  endfunction

  function automatic bit close_line(output res_t r);
    int unsigned t;
    logic [NPAT-1:0] a;
    logic [31:0] kv, val;
    logic [15:0] ml, msg;
    int ev;
    t = trimmed;
    a = alive;
    kv = key_on ? (key_hex ? as_hexcode(keynum) : as_decimal(keynum)) : 32'd0;
    ml = comma_n >= 2 ? comma0 : 16'd0;
    ev = -1;
    val = 0;
    msg = 0;
    line_clear();
    if (t == 0) return 0;
    if (exact(a, t, P_READY)) begin link = 1; ev = EV_READY; end
    else if (starts(a, t, P_WIFI)) begin
      if (starts(a, t, P_WCONN)) begin link = 2; ev = EV_WCONN; end
      else if (starts(a, t, P_WGOT)) begin link = 3; ev = EV_WGOT; end
      else if (starts(a, t, P_WDISC)) begin link = 4; ev = EV_WLOST; end
    end else if (starts(a, t, P_MQTT)) begin
      if (starts(a, t, P_MCONN)) begin broker = 1; ev = EV_MCONN; val = kv; end
      else if (starts(a, t, P_MDISC)) begin broker = 0; ev = EV_MDISC; val = kv; end
      else if (starts(a, t, P_PUBOK)) ev = EV_PUBOK;
      else if (starts(a, t, P_PUBFAIL)) ev = EV_PUBFAIL;
      else if (starts(a, t, P_SUBRECV)) begin ev = EV_MSG; val = kv; msg = ml; end
    end else if (starts(a, t, P_HTTP)) begin ev = EV_HTTP; val = kv & 32'hffff; end
    else if (starts(a, t, P_CWJAP)) begin link = 4; ev = EV_JOINERR; val = kv; end
    else if (starts(a, t, P_ERRC)) begin ev = EV_DEVERR; val = kv; end
    else if (starts(a, t, P_BUSY)) begin
      if (waiting) begin waiting = 0; ev = EV_BUSY; end
    end else if (starts(a, t, P_PROMPT)) ev = EV_PROMPT;
    else if (waiting) begin
      if (exact(a, t, P_OK)) begin waiting = 0; ev = EV_OK; end
      else if (exact(a, t, P_ERROR) || exact(a, t, P_FAIL)) begin
        waiting = 0;
        ev = EV_ERROR;
      end else ev = EV_LINE;
    end
    if (ev < 0) return 0;
    r = make_event(5'(ev), val, msg, 8'd0, 0, 0);
    return 1;
  endfunction

  function automatic bit line_char(logic [7:0] c, output res_t r);
    int unsigned pos;
    pos = held;
    if (c == 8'h0a || pos >= LINE_MAX - 1) return close_line(r);
    for (int i = 0; i < NPAT; i++)
      if (pos < words[i].len() && words[i][pos] != c) alive[i] = 1'b0;
    if (pos == 3 && alive[P_IPD]) begin
      mode = MODE_HDR;
      hdr_seen = 4;
      hdr_comma = 0;
      keynum = '0;
      return 0;
    end
    if (key_on) keynum = digits_take(keynum, c, key_hex);
    else begin
      for (int k = 0; k < 6; k++) begin
        if (pos == key_at[k] && alive[key_word[k]]) begin
          key_on = 1;
          key_hex = (key_word[k] == P_ERRC);
          if (c != "=" && c != ":") keynum = digits_take(keynum, c, key_hex);
          break;
        end
      end
    end
    if (c == ",") begin
      comma1 = comma0;
      comma0 = as_decimal(commanum) & 32'hffff;
      if (comma_n < 2) comma_n++;
      commanum = '0;
    end else commanum = digits_take(commanum, c, 0);
    if (c != 8'h0d && c != " ") trimmed = pos + 1;
    held = pos + 1;
    return 0;
  endfunction

  function automatic bit header_char(logic [7:0] c, output res_t r);
    logic [31:0] len;
    hdr_seen++;
    if (c == ":") begin
      len = as_decimal(keynum);
      mode = MODE_LINE;
      line_clear();
      if (!hdr_comma || len < 1 || len > 65535) begin
        r = make_event(EV_PAYLOAD, 0, 0, 0, 0, 1);
        return 1;
      end
      body_left = len;
      discard = (fill + len > FBUF_MAX);
      mode = MODE_BODY;
      if (discard) begin
        r = make_event(EV_PAYLOAD, 0, 0, 0, 0, 1);
        return 1;
      end
      return 0;
    end
    if (hdr_seen >= HDR_MAX) begin
      mode = MODE_LINE;
      line_clear();
      held = HDR_MAX - 1;
      alive = '0;
      trimmed = held;
      r = make_event(EV_PAYLOAD, 0, 0, 0, 0, 1);
      return 1;
    end
    if (c == ",") begin hdr_comma = 1; keynum = '0; end
    else keynum = digits_take(keynum, c, 0);
    return 0;
  endfunction

  function automatic bit body_char(logic [7:0] c, output res_t r);
    bit last;
    if (body_left == 0) begin
      mode = MODE_LINE;
      return line_char(c, r);
    end
    body_left--;
    last = (body_left == 0);
    if (last) mode = MODE_LINE;
    if (discard) begin
      if (last) discard = 0;
      return 0;
    end
    if (fill < FBUF_MAX) fill++;
    r = make_event(EV_PAYLOAD, 0, 0, c, last, 0);
    return 1;
  endfunction

  function automatic bit parse_step(logic [1:0] act, logic [7:0] c, output res_t r);
    case (act)
      ACT_CMD: begin waiting = 1; return 0; end
      ACT_ABORT: begin waiting = 0; return 0; end
      ACT_DRAIN: begin fill = 0; return 0; end
      default: ;
    endcase
    if (mode == MODE_HDR) return header_char(c, r);
    if (mode == MODE_BODY) return body_char(c, r);
    return line_char(c, r);
  endfunction

  function automatic void parser_reset();
    mode = MODE_LINE;
    line_clear();
    body_left = 0;
    fill = 0;
    discard = 0;
    link = 0;
    broker = 0;
    waiting = 0;
    hdr_seen = 0;
    hdr_comma = 0;
  endfunction

  initial parser_reset();

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // result checking first, then prediction of the request taken at this edge
  always @(posedge clk) begin
    res_t r, w;
    bit has;
    cyc++;
    if (cyc > LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
    if (!rst && out_valid && out_ready) begin
      if (events_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual event %0d", $time, event_res);
        errors++;
      end else begin
        w = events_due.pop_front();
        check_field("event_res", w.event_res, event_res);
        check_field("value", w.value, value);
        check_field("message_length", w.message_length, message_length);
        check_field("payload_byte", w.payload_byte, payload_byte);
        check_field("last_of_frame", w.last_of_frame, last_of_frame);
        check_field("frame_dropped", w.frame_dropped, frame_dropped);
        check_field("wifi_status", w.wifi_status, wifi_status);
        check_field("mqtt_up", w.mqtt_up, mqtt_up);
        check_field("command_busy", w.command_busy, command_busy);
      end
    end
    if (!rst && in_valid && in_ready) begin
      r = '0;
      has = parse_step(action, rx_byte, r);
      if (cur_fixed) begin
        r.event_res = cur_ev;
        has = 1;
      end
      if (has) events_due.push_back(r);
    end
  end

  task automatic add_req(logic [1:0] a, logic [7:0] c, bit fx = 0, logic [4:0] ev = 0);
    request_t q;
    q.act = a;
    q.chr = c;
    q.fixed = fx;
    q.ev = ev;
    stim_q.push_back(q);
  endtask

  task automatic add_text(string s, bit fx = 0, logic [4:0] ev = 0);
    for (int i = 0; i < s.len(); i++)
      add_req(ACT_BYTE, s[i], fx && i == s.len() - 1, ev);
  endtask

  task automatic add_rand_bytes(int n, bit no_colon);
    logic [7:0] c;
    for (int i = 0; i < n; i++) begin
      c = 8'($urandom_range(0, 255));
      if (no_colon && c == ":") c = "a";
      add_req(ACT_BYTE, c);
    end
  endtask

  function automatic string line_end();
    case ($urandom_range(0, 2))
      0: return "\n";
      1: return "\r\n";
      default: return " \r\n";
    endcase
  endfunction

  function automatic string signed_num();
    return $sformatf("%s%0d", ($urandom_range(0, 4) == 0) ? "-" : "", $urandom());
  endfunction

  function automatic string rand_line();
    case ($urandom_range(0, 18))
      0: return "ready";
      1: return "WIFI CONNECTED";
      2: return "WIFI GOT IP";
      3: return "WIFI DISCONNECT";
      4: return $sformatf("+MQTTCONNECTED:%0d,1", $urandom_range(0, 9));
      5: return $sformatf("+MQTTDISCONNECTED:%s", signed_num());
      6: return "+MQTTPUB:OK";
      7: return "+MQTTPUB:FAIL";
      8: return $sformatf("+MQTTSUBRECV:%0d,\"t\",%0d,xy", $urandom_range(0, 9),
                          $urandom_range(0, 99999));
      9: return $sformatf("+HTTPCLIENT:%s,d", signed_num());
      10: return $sformatf("+CWJAP:%s", signed_num());
      11: return $sformatf("ERR CODE:0x%0h", $urandom());
      12: return $sformatf("ERR CODE:%0h%0h", $urandom(), $urandom());
      13: return "busy p...";
      14: return "OK";
      15: return "ERROR";
      16: return "FAIL";
      17: return ">";
      default: return "  some text";
    endcase
  endfunction

  task automatic add_frame();
    int len;
    int k;
    k = $urandom_range(0, 99);
    len = (k < 3) ? $urandom_range(1000, 2100) : $urandom_range(1, 20);
    if (k >= 95) begin
      case ($urandom_range(0, 2))
        0: add_text("+IPD,0:");
        1: add_text("+IPD,99999:");
        default: add_text("+IPD:");
      endcase
      return;
    end
    add_text($sformatf("+IPD,%s%0d:", $urandom_range(0, 1) ? "0," : "", len));
    add_rand_bytes(len, 0);
  endtask

  task automatic build_stimulus();
    row_t rows[$];
    int base;
    int k;
    rows = '{
      '{ACT_BYTE, "ready\n", 1, EV_READY},
      '{ACT_BYTE, "WIFI CONNECTED\r\n", 1, EV_WCONN},
      '{ACT_BYTE, "WIFI GOT IP\r\n", 1, EV_WGOT},
      '{ACT_BYTE, "WIFI DISCONNECT\n", 1, EV_WLOST},
      '{ACT_BYTE, "+MQTTCONNECTED:0,1\n", 1, EV_MCONN},
      '{ACT_BYTE, "+MQTTSUBRECV:0,\"t\",5,hello\n", 1, EV_MSG},
      '{ACT_BYTE, "+MQTTPUB:OK\n", 1, EV_PUBOK},
      '{ACT_BYTE, "+MQTTPUB:FAIL\n", 1, EV_PUBFAIL},
      '{ACT_BYTE, "+MQTTDISCONNECTED:4\n", 1, EV_MDISC},
      '{ACT_BYTE, "+HTTPCLIENT:70000,xx\n", 1, EV_HTTP},
      '{ACT_BYTE, "+CWJAP:-99999999999\n", 1, EV_JOINERR},
      '{ACT_BYTE, "ERR CODE:0x1FFFFFFFF\n", 1, EV_DEVERR},
      '{ACT_BYTE, ">\n", 1, EV_PROMPT},
      '{ACT_CMD, "", 0, 0},
      '{ACT_BYTE, "OK\r\n", 1, EV_OK},
      '{ACT_CMD, "", 0, 0},
      '{ACT_BYTE, "busy p...\n", 1, EV_BUSY},
      '{ACT_CMD, "", 0, 0},
      '{ACT_BYTE, "FAIL\n", 1, EV_ERROR},
      '{ACT_CMD, "", 0, 0},
      '{ACT_BYTE, "what\n", 1, EV_LINE},
      '{ACT_ABORT, "", 0, 0},
      '{ACT_BYTE, "+IPD,0,5:hello", 0, 0},
      '{ACT_BYTE, "+IPD,0,0:", 1, EV_PAYLOAD},
      '{ACT_BYTE, "+IPD:", 1, EV_PAYLOAD},
      '{ACT_BYTE, "+IPDaaaaaaaaaaaaaaaaaaaa", 1, EV_PAYLOAD},
      '{ACT_BYTE, "\n", 0, 0},
      '{ACT_DRAIN, "", 0, 0}
    };
    foreach (rows[i]) begin
      if (rows[i].act != ACT_BYTE) add_req(rows[i].act, 8'd0);
      else add_text(rows[i].txt, rows[i].fixed, rows[i].ev);
    end
    base = stim_q.size();
    while (stim_q.size() < base + 1600) begin
      k = $urandom_range(0, 99);
      if (k < 30) add_frame();
      else if (k < 50) add_text({rand_line(), line_end()});
      else if (k < 57) add_req(ACT_CMD, 8'($urandom_range(0, 255)));
      else if (k < 60) add_req(ACT_ABORT, 8'($urandom_range(0, 255)));
      else if (k < 65) add_req(ACT_DRAIN, 8'($urandom_range(0, 255)));
      else if (k < 73) add_rand_bytes($urandom_range(1, 10), 0);
      else if (k < 77) begin
        add_rand_bytes($urandom_range(125, 140), 0);
        add_text("\n");
      end else if (k < 81) begin
        add_text("+IPD");
        add_rand_bytes(25, 1);
      end else begin
        add_req(ACT_CMD, 8'd0);
        add_text({rand_line(), line_end()});
      end
    end
  endtask

  task automatic send_requests();
    int g;
    bit idle_on;
    bit pause;
    idle_on = 1;
    foreach (stim_q[i]) begin
      if (i % 100 == 0) idle_on = ($urandom_range(0, 3) != 0);
      if (i == 700) stall_req = 1;
      pause = (i == 1200);
      g = idle_on ? $urandom_range(0, 17) : 0;
      if (g > 0 || pause) begin
        in_valid <= 1'b0;
        cur_fixed <= 1'b0;
        if (pause) begin
          @(posedge clk);
          while (events_due.size() != 0) @(posedge clk);
        end
        repeat (g) @(posedge clk);
      end
      in_valid <= 1'b1;
      action <= stim_q[i].act;
      rx_byte <= stim_q[i].chr;
      cur_fixed <= stim_q[i].fixed;
      cur_ev <= stim_q[i].ev;
      @(posedge clk);
      while (!in_ready) @(posedge clk);
    end
    in_valid <= 1'b0;
    cur_fixed <= 1'b0;
  endtask

  // result side back-pressure, with one long hold to fill the block
  initial begin
    int g;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      g = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17);
      if (stall_req) begin
        stall_req = 0;
        g = 400;
      end
      if (g > 0) begin
        out_ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin
    build_stimulus();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_requests();
    @(posedge clk);
    while (events_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0 && events_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
